/* sv/assert_macros.svh */
// assertion helpers for the hasher
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// immediate implication, checked every cycle outside reset
`define CHK_IMPL(lbl, clk, rstn, a, c) \
lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) else $error("lbl");
// next-cycle implication
`define CHK_NEXT(lbl, clk, rstn, a, c) \
lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) else $error("lbl");
`endif

/* sv/sha_pkg.sv */
`default_nettype none
package sha_pkg;
	localparam int QUEUE_DEPTH = 4;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       is_last;
	} in_word_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        final_word;
	} out_word_t;

	// one classified entry for the back end
	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       is_last;
	} cmd_t;

	localparam logic [7:0] PAD_BYTE = 8'h80;

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] INIT_H [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	function automatic logic [31:0] rotr(input logic [31:0] x, input logic [4:0] s);
		rotr = (x >> s) | (x << (6'd32 - {1'b0, s}));
	endfunction
endpackage
`default_nettype wire

/* sv/sha_cmd_fifo.sv */
`default_nettype none
`include "assert_macros.svh"
module sha_cmd_fifo #(
	parameter int DEPTH = sha_pkg::QUEUE_DEPTH
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   wr_en,
	input  wire sha_pkg::cmd_t    wr_data,
	output logic                  full,
	input  wire                   rd_en,
	output sha_pkg::cmd_t         rd_data,
	output logic                  empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	sha_pkg::cmd_t   mem_q [DEPTH];
	logic [AW-1:0]   wp_q, rp_q;
	logic [AW:0]     cnt_q;

	assign full    = (cnt_q == (AW+1)'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr_en && !full) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en && !full)
				wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			if (rd_en && !empty)
				rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(wr_en && !full) - (AW+1)'(rd_en && !empty);
		end
	end

	`CHK_IMPL(a_cnt_range, clk, arst_n, 1'b1, cnt_q <= (AW+1)'(DEPTH))
	`CHK_NEXT(a_fill_grows, clk, arst_n, wr_en && !full && !(rd_en && !empty), !empty)
	`CHK_IMPL(a_not_full_empty, clk, arst_n, 1'b1, !(full && empty))
endmodule
`default_nettype wire

/* sv/sha_core.sv */
`default_nettype none
`include "assert_macros.svh"
module sha_core (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire sha_pkg::cmd_t       cmd,
	input  wire                      cmd_valid,
	output logic                     cmd_take,
	output sha_pkg::out_word_t       res,
	output logic                     empty,
	input  wire                      pop
);
	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_PAD  = 6'b000010,
		ST_LEN  = 6'b000100,
		ST_RND  = 6'b001000,
		ST_ADD  = 6'b010000,
		ST_OUT  = 6'b100000
	} state_t;

	state_t       st_q;
	logic [5:0]   fill_q;
	logic [63:0]  bits_q;
	logic [31:0]  h_q [8];
	logic [31:0]  v_q [8];
	// block words, big-endian bytes; doubles as the schedule window
	logic [31:0]  w_q [16];
	logic [5:0]   rnd_q;
	logic         fin_q;
	logic         pad_first_q;
	logic         len_done_q;
	logic [2:0]   oi_q;

	logic [31:0] s0, s1, t1, t2, w16;
	logic        byte_wr;
	logic [7:0]  byte_val;

	always_comb begin
		s0  = sha_pkg::rotr(w_q[1], 5'd7) ^ sha_pkg::rotr(w_q[1], 5'd18) ^ (w_q[1] >> 3);
		s1  = sha_pkg::rotr(w_q[14], 5'd17) ^ sha_pkg::rotr(w_q[14], 5'd19)
			^ (w_q[14] >> 10);
		w16 = s1 + w_q[9] + s0 + w_q[0];
		t1  = v_q[7] + (sha_pkg::rotr(v_q[4], 5'd6) ^ sha_pkg::rotr(v_q[4], 5'd11)
			^ sha_pkg::rotr(v_q[4], 5'd25)) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
			+ sha_pkg::ROUND_K[rnd_q] + w_q[0];
		t2  = (sha_pkg::rotr(v_q[0], 5'd2) ^ sha_pkg::rotr(v_q[0], 5'd13)
			^ sha_pkg::rotr(v_q[0], 5'd22))
			+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
	end

	assign cmd_take = (st_q == ST_IDLE) && cmd_valid;
	assign empty    = (st_q != ST_OUT);
	assign res.digest_word = h_q[oi_q];
	assign res.word_index  = oi_q;
	assign res.final_word  = (oi_q == 3'd7);

	// message bytes while idle, pad bytes while padding
	assign byte_wr  = (cmd_take && cmd.has_byte) || (st_q == ST_PAD);
	assign byte_val = (st_q == ST_PAD) ? (pad_first_q ? sha_pkg::PAD_BYTE : 8'h00)
		: cmd.data_byte;

	always_ff @(posedge clk) begin
		if (st_q == ST_RND) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= w16;
			v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end else begin
			for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
			if (st_q == ST_LEN) begin
				w_q[14] <= bits_q[63:32];
				w_q[15] <= bits_q[31:0];
			end else if (byte_wr) begin
				case (fill_q[1:0])
					2'd0: w_q[fill_q[5:2]][31:24] <= byte_val;
					2'd1: w_q[fill_q[5:2]][23:16] <= byte_val;
					2'd2: w_q[fill_q[5:2]][15:8]  <= byte_val;
					default: w_q[fill_q[5:2]][7:0] <= byte_val;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			fill_q      <= '0;
			bits_q      <= '0;
			rnd_q       <= '0;
			fin_q       <= 1'b0;
			pad_first_q <= 1'b0;
			len_done_q  <= 1'b0;
			oi_q        <= '0;
			for (int i = 0; i < 8; i++) h_q[i] <= sha_pkg::INIT_H[i];
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (cmd_take) begin
						fin_q       <= cmd.is_last;
						pad_first_q <= 1'b1;
						len_done_q  <= 1'b0;
						if (cmd.has_byte) begin
							fill_q <= fill_q + 1'b1;
							bits_q <= bits_q + 64'd8;
						end
						if (cmd.has_byte && fill_q == 6'd63) begin
							st_q <= ST_RND; rnd_q <= '0;
						end else if (cmd.is_last) begin
							st_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					// 0x80 first, then zeros up to the length field or block end
					pad_first_q <= 1'b0;
					fill_q      <= fill_q + 1'b1;
					if (fill_q == 6'd63) begin
						st_q <= ST_RND; rnd_q <= '0;
					end else if (fill_q == 6'd55) begin
						st_q <= ST_LEN;
					end
				end
				ST_LEN: begin
					st_q       <= ST_RND;
					rnd_q      <= '0;
					fill_q     <= '0;
					len_done_q <= 1'b1;
				end
				ST_RND: begin
					if (rnd_q == 6'd63) st_q <= ST_ADD;
					rnd_q <= rnd_q + 1'b1;
				end
				ST_ADD: begin
					for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
					if (!fin_q) st_q <= ST_IDLE;
					else if (len_done_q) begin
						st_q <= ST_OUT; oi_q <= '0;
					end else st_q <= ST_PAD;
				end
				ST_OUT: begin
					if (pop) begin
						oi_q <= oi_q + 1'b1;
						if (oi_q == 3'd7) begin
							st_q   <= ST_IDLE;
							fill_q <= '0;
							bits_q <= '0;
							fin_q  <= 1'b0;
							for (int i = 0; i < 8; i++) h_q[i] <= sha_pkg::INIT_H[i];
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	`CHK_IMPL(a_no_take_busy, clk, arst_n, st_q != ST_IDLE, !cmd_take)
	`CHK_NEXT(a_out_hold, clk, arst_n, st_q == ST_OUT && !pop, st_q == ST_OUT)
	`CHK_NEXT(a_rnd_to_add, clk, arst_n, st_q == ST_RND && rnd_q == 6'd63, st_q == ST_ADD)
endmodule
`default_nettype wire

/* sv/sha256_stream_hasher_unit.sv */
// channel | signals            | moves
// input   | push, full, in     | one byte word per accept
// result  | pop, empty, out    | eight digest words per closing word
//
// a byte word passes through the front queue and is then registered in the core
// a full block runs 64 rounds and then an add step in the core
// closing pads one byte a cycle up to byte 55, writes the length field, then compresses the block
// a pad that runs past byte 55 first fills and compresses an extra block
// reset is asynchronous and restores the initial hash values
// input stalls only while the command queue is full; the core takes nothing while busy
`default_nettype none
module sha256_stream_hasher_unit #(
	parameter int QDEPTH = sha_pkg::QUEUE_DEPTH
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      push,
	output logic                     full,
	input  wire sha_pkg::in_word_t   in,
	output logic                     empty,
	input  wire                      pop,
	output sha_pkg::out_word_t       out
);
	sha_pkg::cmd_t cmd_w, cmd_r;
	logic          q_empty, take;

	// front: classify the word into a command
	assign cmd_w.data_byte = in.data_byte;
	assign cmd_w.has_byte  = in.has_byte;
	assign cmd_w.is_last   = in.is_last;

	sha_cmd_fifo #(.DEPTH(QDEPTH)) u_q (
		.clk(clk), .arst_n(arst_n), .wr_en(push), .wr_data(cmd_w), .full(full),
		.rd_en(take), .rd_data(cmd_r), .empty(q_empty)
	);

	sha_core u_core (
		.clk(clk), .arst_n(arst_n), .cmd(cmd_r), .cmd_valid(!q_empty),
		.cmd_take(take), .res(out), .empty(empty), .pop(pop)
	);
endmodule
`default_nettype wire
